// File: src/local_minimum_counter_defines.svh
// Assertion helpers for local_minimum_counter
`ifndef LOCAL_MINIMUM_COUNTER_DEFINES_SVH
`define LOCAL_MINIMUM_COUNTER_DEFINES_SVH

// condition holds at every edge out of reset
`define LMC_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("lmc check failed");

// consequent holds in the cycle after the antecedent
`define LMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmc check failed");

`endif

// File: src/lmc_pkg.sv
package lmc_pkg;

	localparam int LMC_MAX_WIDTH     = 1024;
	localparam int LMC_MAX_HEIGHT    = 4096;
	localparam int LMC_SAMPLE_BITS   = 16;
	localparam int LMC_FW_BITS       = 11;
	localparam int LMC_FH_BITS       = 13;
	localparam int LMC_CFG_DATA_BITS = 13;
	localparam int LMC_CFG_IDX_BITS  = 1;
	localparam int LMC_TALLY_BITS    = 23;
	localparam int LMC_QUEUE_DEPTH   = 4;
	localparam int LMC_SIZE_RESET    = 1024;

	// neighbor offsets (row, column)
	localparam int LMC_DROW [8] = '{1, 1, 1, 0, 0, -1, -1, -1};
	localparam int LMC_DCOL [8] = '{1, 0, -1, 1, -1, 0, -1, 1};

	typedef enum logic [LMC_CFG_IDX_BITS-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} lmc_cfg_idx_t;

	// position class of one sample, worked out by the front end
	typedef struct packed {
		logic last_col;
		logic last_row;
		logic col_ge1;
		logic col_ge2;
		logic row_ge1;
		logic row_ge2;
	} lmc_flags_t;

endpackage

// File: src/lmc_fifo.sv
module lmc_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [DW-1:0]                push_data,
	input  logic                         inflight,
	output logic                         room,
	output logic                         pop_valid,
	input  logic                         pop,
	output logic [DW-1:0]                pop_data,
	output logic [$clog2(DEPTH):0]       count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DW-1:0]  mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];
	assign count     = ($clog2(DEPTH) + 1)'(cnt_q);
	// leave a slot for the word still in the front end
	assign room      = ((cnt_q + (AW + 1)'(inflight)) < (AW + 1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// File: src/lmc_front.sv
module lmc_front #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [lmc_pkg::LMC_CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [lmc_pkg::LMC_CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic signed [SAMPLE_BITS-1:0]              sample_value,
	input  logic                                       room,
	output logic                                       push,
	output lmc_pkg::lmc_flags_t                        push_flags,
	output logic signed [SAMPLE_BITS-1:0]              push_up,
	output logic signed [SAMPLE_BITS-1:0]              push_mid,
	output logic signed [SAMPLE_BITS-1:0]              push_x
);
	import lmc_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int SW = SAMPLE_BITS;

	logic [LMC_FW_BITS-1:0] fw_q;
	logic [LMC_FH_BITS-1:0] fh_q;
	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [CW:0]            w_eff;
	logic [RW:0]            h_eff;
	logic                   accept;
	lmc_flags_t             flags;

	// each line store entry holds {row two above, row above}
	logic [2*SW-1:0]        line_mem [MAX_WIDTH];
	logic [2*SW-1:0]        rd_q;

	logic                   s1_valid;
	lmc_flags_t             flags_s1;
	logic signed [SW-1:0]   x_s1;
	logic [CW-1:0]          col_s1;
	logic                   byp_s1;
	logic [2*SW-1:0]        fwd_s1;
	logic [2*SW-1:0]        entry;

	assign cfg_ready = 1'b1;
	assign in_ready  = room;
	assign accept    = in_valid && room;

	always_comb begin
		if (fw_q == '0) begin
			w_eff = (CW + 1)'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w_eff = (CW + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW + 1)'(fw_q);
		end
		if (fh_q == '0) begin
			h_eff = (RW + 1)'(1);
		end else if (32'(fh_q) > MAX_HEIGHT) begin
			h_eff = (RW + 1)'(MAX_HEIGHT);
		end else begin
			h_eff = (RW + 1)'(fh_q);
		end
		flags.last_col = (({1'b0, col_q} + (CW + 1)'(1)) >= w_eff);
		flags.last_row = (({1'b0, row_q} + (RW + 1)'(1)) >= h_eff);
		flags.col_ge1  = (col_q != '0);
		flags.col_ge2  = (col_q > CW'(1));
		flags.row_ge1  = (row_q != '0);
		flags.row_ge2  = (row_q > RW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= LMC_FW_BITS'(LMC_SIZE_RESET);
			fh_q     <= LMC_FH_BITS'(LMC_SIZE_RESET);
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  fw_q <= cfg_data[LMC_FW_BITS-1:0];
					CFG_FRAME_HEIGHT: fh_q <= cfg_data[LMC_FH_BITS-1:0];
					default: ;
				endcase
			end
			s1_valid <= accept;
			if (accept) begin
				if (!flags.last_col) begin
					col_q <= col_q + 1'b1;
				end else begin
					col_q <= '0;
					row_q <= flags.last_row ? '0 : row_q + 1'b1;
				end
			end
		end
	end

	// line store: read at accept, written back in the next cycle
	assign entry = byp_s1 ? fwd_s1 : rd_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= line_mem[col_q];
		end
		if (s1_valid) begin
			line_mem[col_s1] <= {entry[SW-1:0], x_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
			x_s1     <= sample_value;
			col_s1   <= col_q;
			// same column written by the word ahead (single-column frames)
			byp_s1   <= s1_valid && (col_s1 == col_q);
			fwd_s1   <= {entry[SW-1:0], x_s1};
		end
	end

	assign push       = s1_valid;
	assign push_flags = flags_s1;
	assign push_up    = entry[2*SW-1:SW];
	assign push_mid   = entry[SW-1:0];
	assign push_x     = x_s1;
endmodule

// File: src/lmc_back.sv
module lmc_back #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   pop_valid,
	output logic                                   pop,
	input  lmc_pkg::lmc_flags_t                    flags,
	input  logic signed [SAMPLE_BITS-1:0]          up,
	input  logic signed [SAMPLE_BITS-1:0]          mid,
	input  logic signed [SAMPLE_BITS-1:0]          x,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [lmc_pkg::LMC_TALLY_BITS-1:0]     local_min_count
);
	import lmc_pkg::*;

	localparam int SW = SAMPLE_BITS;

	typedef logic signed [SW-1:0] win_t [3][3];

	win_t                      win_q;
	win_t                      nwin;
	logic [LMC_TALLY_BITS-1:0] tally_q;
	logic [LMC_TALLY_BITS-1:0] tally_next;
	logic [LMC_TALLY_BITS-1:0] count_q;
	logic                      out_valid_q;
	logic [2:0]                rok, cok;
	logic                      m11, m12, m21, m22;
	logic [2:0]                inc;
	logic                      final_word;
	logic                      out_free;

	function automatic logic is_min(input win_t w, input int rc, input int cc,
			input logic [2:0] rk, input logic [2:0] ck);
		logic ok;
		int   r;
		int   c;
		ok = 1'b1;
		for (int k = 0; k < 8; k++) begin
			r = rc + LMC_DROW[k];
			c = cc + LMC_DCOL[k];
			if (r >= 0 && r <= 2 && c >= 0 && c <= 2) begin
				if (rk[r] && ck[c] && !(w[rc][cc] < w[r][c])) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nwin[r][0] = win_q[r][1];
			nwin[r][1] = win_q[r][2];
		end
		nwin[0][2] = up;
		nwin[1][2] = mid;
		nwin[2][2] = x;
		// bit 0 is the oldest row / column of the window
		rok = {1'b1, flags.row_ge1, flags.row_ge2};
		cok = {1'b1, flags.col_ge1, flags.col_ge2};
		// centre, right column at row end, bottom row at frame end, corner
		m11 = flags.row_ge1 && flags.col_ge1 && is_min(nwin, 1, 1, rok, cok);
		m12 = flags.last_col && flags.row_ge1 && is_min(nwin, 1, 2, rok, cok);
		m21 = flags.last_row && flags.col_ge1 && is_min(nwin, 2, 1, rok, cok);
		m22 = flags.last_row && flags.last_col && is_min(nwin, 2, 2, rok, cok);
		inc = 3'(m11) + 3'(m12) + 3'(m21) + 3'(m22);
		tally_next = tally_q + LMC_TALLY_BITS'(inc);
	end

	assign final_word      = flags.last_col && flags.last_row;
	assign out_free        = !out_valid_q || out_ready;
	assign pop             = pop_valid && (!final_word || out_free);
	assign out_valid       = out_valid_q;
	assign local_min_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				win_q <= nwin;
				if (final_word) begin
					out_valid_q <= 1'b1;
					tally_q     <= '0;
				end else begin
					tally_q <= tally_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && final_word) begin
			count_q <= tally_next;
		end
	end
endmodule

// File: src/local_minimum_counter.sv
// Strict 8-neighbor local minimum count over one raster frame.
// Throughput: one sample per cycle while the queue has room; the line store is read on
//   accept and written back in the next cycle, and the window compare takes one queued
//   word per cycle, but holds a frame's final word until the result slot is free.
// Reset: positions, tally, queue and window clear; size registers go to 1024 x 1024.
//   The line stores are not cleared and need no clearing pass.
`include "local_minimum_counter_defines.svh"

module local_minimum_counter #(
	parameter int MAX_WIDTH   = lmc_pkg::LMC_MAX_WIDTH,
	parameter int MAX_HEIGHT  = lmc_pkg::LMC_MAX_HEIGHT,
	parameter int SAMPLE_BITS = lmc_pkg::LMC_SAMPLE_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lmc_pkg::LMC_CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [lmc_pkg::LMC_CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [SAMPLE_BITS-1:0]          sample_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [lmc_pkg::LMC_TALLY_BITS-1:0]     local_min_count
);
	import lmc_pkg::*;

	localparam int SW    = SAMPLE_BITS;
	localparam int FLW   = $bits(lmc_flags_t);
	localparam int DW    = 3 * SW + FLW;
	localparam int DEPTH = LMC_QUEUE_DEPTH;

	logic                     room;
	logic                     push;
	lmc_flags_t               push_flags;
	logic signed [SW-1:0]     push_up, push_mid, push_x;
	logic                     pop_valid, pop;
	logic [DW-1:0]            pop_data;
	logic [$clog2(DEPTH):0]   q_count;
	lmc_flags_t               q_flags;
	logic signed [SW-1:0]     q_up, q_mid, q_x;

	lmc_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.room         (room),
		.push         (push),
		.push_flags   (push_flags),
		.push_up      (push_up),
		.push_mid     (push_mid),
		.push_x       (push_x)
	);

	lmc_fifo #(
		.DW    (DW),
		.DEPTH (DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_flags, push_up, push_mid, push_x}),
		.inflight  (push),
		.room      (room),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.count     (q_count)
	);

	assign {q_flags, q_up, q_mid, q_x} = pop_data;

	lmc_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop             (pop),
		.flags           (q_flags),
		.up              (q_up),
		.mid             (q_mid),
		.x               (q_x),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.local_min_count (local_min_count)
	);

	`LMC_ASSERT_ALWAYS(a_queue_bound, 32'(q_count) <= DEPTH)
	`LMC_ASSERT_ALWAYS(a_no_push_full, !(push && !pop && 32'(q_count) == DEPTH))
	`LMC_ASSERT_NEXT(a_accept_pushes, in_valid && in_ready, push)
	`LMC_ASSERT_ALWAYS(a_no_pop_empty, !pop || pop_valid)
endmodule

// File: verif/tb_local_minimum_counter.sv
`timescale 1ns / 100ps

module tb_local_minimum_counter;
	import lmc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 700;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [LMC_CFG_IDX_BITS-1:0]   cfg_index;
	logic [LMC_CFG_DATA_BITS-1:0]  cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [LMC_SAMPLE_BITS-1:0] sample_value;
	logic                          out_valid;
	logic                          out_ready;
	logic [LMC_TALLY_BITS-1:0]     local_min_count;

	local_minimum_counter DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample_value(sample_value),
		.out_valid(out_valid), .out_ready(out_ready), .local_min_count(local_min_count)
	);

	// predictor state
	logic signed [LMC_SAMPLE_BITS-1:0] row_above2 [LMC_MAX_WIDTH];
	logic signed [LMC_SAMPLE_BITS-1:0] row_above1 [LMC_MAX_WIDTH];
	logic signed [LMC_SAMPLE_BITS-1:0] win [3][3];
	int unsigned                 cur_col, cur_row;
	logic [LMC_TALLY_BITS-1:0]   minima_seen;
	logic [LMC_FW_BITS-1:0]      width_reg;
	logic [LMC_FH_BITS-1:0]      height_reg;

	logic [LMC_TALLY_BITS-1:0]   expected_counts [$];
	int  cycle_count, mismatches, samples_sent, counts_checked, frames_sent;
	int  long_hold;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_local_minimum_counter: errors");
			$finish;
		end
	end

	function automatic bit strict_min(int rc, int cc, bit [2:0] rok, bit [2:0] cok);
		int r, c;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++) begin
				r = rc + dr;
				c = cc + dc;
				if ((dr == 0 && dc == 0) || r < 0 || r > 2 || c < 0 || c > 2)
					continue;
				if (!rok[r] || !cok[c])
					continue;
				if (!(win[rc][cc] < win[r][c]))
					return 1'b0;
			end
		return 1'b1;
	endfunction

	task automatic predict_sample(input logic signed [LMC_SAMPLE_BITS-1:0] x);
		int unsigned w, h;
		bit last_col, last_row;
		bit [2:0] rok, cok;
		logic signed [LMC_SAMPLE_BITS-1:0] up, mid;
		w = (width_reg == 0) ? 1 : (width_reg > LMC_MAX_WIDTH) ? LMC_MAX_WIDTH : width_reg;
		h = (height_reg == 0) ? 1 : (height_reg > LMC_MAX_HEIGHT) ? LMC_MAX_HEIGHT : height_reg;
		last_col = (cur_col + 1 >= w);
		last_row = (cur_row + 1 >= h);
		up = row_above2[cur_col];
		mid = row_above1[cur_col];
		row_above2[cur_col] = mid;
		row_above1[cur_col] = x;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = x;
		rok = {1'b1, cur_row >= 1, cur_row >= 2};
		cok = {1'b1, cur_col >= 1, cur_col >= 2};
		if (cur_row >= 1 && cur_col >= 1 && strict_min(1, 1, rok, cok)) minima_seen++;
		if (last_col && cur_row >= 1 && strict_min(1, 2, rok, cok)) minima_seen++;
		if (last_row && cur_col >= 1 && strict_min(2, 1, rok, cok)) minima_seen++;
		if (last_row && last_col && strict_min(2, 2, rok, cok)) minima_seen++;
		if (!last_col) begin
			cur_col++;
		end else begin
			cur_col = 0;
			if (!last_row) begin
				cur_row++;
			end else begin
				cur_row = 0;
				expected_counts = {expected_counts, minima_seen};
				minima_seen = '0;
			end
		end
	endtask

	// one sample word, with a random gap before it
	task automatic send_sample(input logic signed [LMC_SAMPLE_BITS-1:0] x);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= x;
		do @(posedge clk); while (!in_ready);
		predict_sample(x);
		samples_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input lmc_cfg_idx_t idx, input logic [LMC_CFG_DATA_BITS-1:0] d);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FRAME_WIDTH) width_reg = d[LMC_FW_BITS-1:0];
		else height_reg = d[LMC_FH_BITS-1:0];
	endtask

	task automatic set_size(input int w, input int h);
		write_reg(CFG_FRAME_WIDTH, LMC_CFG_DATA_BITS'(w));
		write_reg(CFG_FRAME_HEIGHT, LMC_CFG_DATA_BITS'(h));
	endtask

	function automatic int frame_len();
		int w, h;
		w = (width_reg == 0) ? 1 : (width_reg > LMC_MAX_WIDTH) ? LMC_MAX_WIDTH : width_reg;
		h = (height_reg == 0) ? 1 : (height_reg > LMC_MAX_HEIGHT) ? LMC_MAX_HEIGHT : height_reg;
		return w * h;
	endfunction

	// narrow spread near 0 or at extremes makes ties likely; or full range
	task automatic send_random_frame();
		int n, spread;
		n = frame_len();
		spread = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			if (spread == 0) send_sample(LMC_SAMPLE_BITS'($urandom));
			else if (spread == 1)
				send_sample(LMC_SAMPLE_BITS'($signed($urandom_range(0, 6)) - 3));
			else send_sample(LMC_SAMPLE_BITS'($urandom_range(0, 1)
				? 16'sh7fff - $urandom_range(0, 2) : 16'sh8000 + $urandom_range(0, 2)));
		end
		frames_sent++;
	endtask

	task automatic test_directed();
		logic signed [15:0] f3 [9] = '{5, 7, 9, 4, -32768, 6, 8, 1, 3};
		set_size(3, 3);
		foreach (f3[i]) send_sample(f3[i]);
		// zero size registers act as a 1x1 frame, whose one sample counts
		set_size(0, 0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		// flat frame: no strict minimum anywhere
		set_size(4, 3);
		for (int i = 0; i < 12; i++) send_sample(16'sd0);
		frames_sent += 4;
	endtask

	task automatic test_size_extremes();
		set_size(2047, 1);
		send_random_frame();
		set_size(5, 0);
		send_random_frame();
	endtask

	task automatic test_random_frames();
		int start;
		start = samples_sent;
		while (samples_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) set_size($urandom_range(1, 40), $urandom_range(1, 6));
			else set_size($urandom_range(1, 9), $urandom_range(1, 9));
			repeat ($urandom_range(1, 3)) send_random_frame();
		end
	endtask

	task automatic test_backpressure();
		set_size(1, 1);
		drain();
		long_hold = 300;
		repeat (16) send_random_frame();
		set_size(2, 2);
		long_hold = 200;
		repeat (8) send_random_frame();
	endtask

	// result side: random stalls per word, with an occasional long hold-off
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end else begin
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		logic [LMC_TALLY_BITS-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			counts_checked++;
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected count word %0d", local_min_count);
			end else begin
				want = expected_counts.pop_front();
				if (local_min_count !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("count mismatch: expected %0d got %0d", want, local_min_count);
				end
			end
		end
	end

	initial begin
		cycle_count = 0; mismatches = 0; samples_sent = 0; counts_checked = 0;
		frames_sent = 0; long_hold = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = CFG_FRAME_WIDTH; cfg_data = '0;
		in_valid = 1'b0; sample_value = '0;
		foreach (row_above2[i]) begin
			row_above2[i] = '0;
			row_above1[i] = '0;
		end
		foreach (win[r, c]) win[r][c] = '0;
		cur_col = 0; cur_row = 0; minima_seen = '0;
		width_reg = LMC_SIZE_RESET; height_reg = LMC_SIZE_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_size_extremes();
		test_random_frames();
		test_backpressure();

		drain();
		repeat (10) @(posedge clk);
		if (expected_counts.size() != 0) mismatches++;
		$display("%0d samples in %0d frames sent, %0d frame counts checked, %0d mismatches",
			samples_sent, frames_sent, counts_checked, mismatches);
		$display("sizes 1x1 up to a clamped 1024-wide row, zero sizes, ties, extremes, hold-off");
		if (mismatches == 0)
			$display("tb_local_minimum_counter: clean");
		else
			$display("tb_local_minimum_counter: errors");
		$finish;
	end

endmodule
